// ===== sv/bmm_pkg.sv =====
// bmm_pkg: shared types and constants of the bipartite matching block
// holds the beat structs, op codes and default sizes; no dependencies
package bmm_pkg;

    localparam int MAX_LEFT_DEF   = 32;
    localparam int MAX_RIGHT_DEF  = 32;
    localparam int MAX_DEGREE_DEF = 32;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_SOLVE = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] CFG_LEFT_COUNT  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_COUNT = 2'd1;

    localparam logic [5:0] COUNT_RESET = 6'd32;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] left_vertex;
        logic [5:0] right_vertex;
    } item_t;

    typedef struct packed {
        logic       side;
        logic [5:0] vertex;
        logic [5:0] partner;
        logic       in_cover;
        logic [5:0] match_size;
        logic       edge_overflow;
        logic       last;
    } result_t;

endpackage

// ===== sv/bmm_ram.sv =====
// bmm_ram: generic single-port synchronous ram with registered read
// no dependencies
module bmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

// ===== sv/bipartite_max_matching_cover.sv =====
// Bipartite matching block. Clear and add-edge beats are handled in the idle state. A solve
// beat runs Hopcroft-Karp phases and then the Koenig reach marking; every edge inspection
// goes through a request state and a use state because all adjacency lists sit in one
// edge ram with one port and a registered read. The solve then emits one result beat per
// left and right vertex of the clamped counts, one per cycle when the sink does not stall.
// Input is stalled from the solve beat until the last result is loaded.
// depends on bmm_pkg and bmm_ram
module bipartite_max_matching_cover #(
    parameter int MAX_LEFT   = bmm_pkg::MAX_LEFT_DEF,
    parameter int MAX_RIGHT  = bmm_pkg::MAX_RIGHT_DEF,
    parameter int MAX_DEGREE = bmm_pkg::MAX_DEGREE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  bmm_pkg::item_t   item_data,
    output logic             result_valid,
    input  logic             result_stall,
    output bmm_pkg::result_t result_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [5:0]       cfg_data
);

    localparam int LW  = $clog2(MAX_LEFT + 1);
    localparam int RW  = $clog2(MAX_RIGHT + 1);
    localparam int DW  = $clog2(MAX_DEGREE + 1);
    localparam int AW  = $clog2(MAX_LEFT * MAX_DEGREE);
    localparam int EDW = $clog2(MAX_RIGHT);
    localparam int TW  = $clog2(MAX_LEFT + 2);
    localparam int VW  = $clog2(MAX_LEFT + 2);
    localparam int EW  = $clog2(MAX_LEFT + MAX_RIGHT + 2);
    localparam int QW  = $clog2(MAX_LEFT);

    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_BFS_INIT   = 5'd1;
    localparam logic [4:0] S_BFS_SEED   = 5'd2;
    localparam logic [4:0] S_BFS_POP    = 5'd3;
    localparam logic [4:0] S_BFS_REQ    = 5'd4;
    localparam logic [4:0] S_BFS_USE    = 5'd5;
    localparam logic [4:0] S_AUG_SCAN   = 5'd6;
    localparam logic [4:0] S_DFS_TOP    = 5'd7;
    localparam logic [4:0] S_DFS_CREQ   = 5'd8;
    localparam logic [4:0] S_DFS_COMMIT = 5'd9;
    localparam logic [4:0] S_DFS_REQ    = 5'd10;
    localparam logic [4:0] S_DFS_USE    = 5'd11;
    localparam logic [4:0] S_MARK_SCAN  = 5'd12;
    localparam logic [4:0] S_MARK_POP   = 5'd13;
    localparam logic [4:0] S_MARK_REQ   = 5'd14;
    localparam logic [4:0] S_MARK_USE   = 5'd15;
    localparam logic [4:0] S_EMIT       = 5'd16;

    localparam logic [1:0] RES_PEND = 2'd0;
    localparam logic [1:0] RES_FAIL = 2'd1;
    localparam logic [1:0] RES_OK   = 2'd2;

    logic [4:0]     state_reg;
    logic [5:0]     left_count_reg;
    logic [5:0]     right_count_reg;
    logic           overflow_reg;
    logic [DW-1:0]  degree_reg [1:MAX_LEFT];
    logic [RW-1:0]  left_partner_reg [1:MAX_LEFT];
    logic [LW-1:0]  right_partner_reg [1:MAX_RIGHT];
    logic [TW-1:0]  layer_reg [1:MAX_LEFT];
    logic           visited_reg [1:MAX_LEFT];
    logic           reach_left_reg [1:MAX_LEFT];
    logic           reach_right_reg [1:MAX_RIGHT];
    logic [LW-1:0]  queue_reg [0:MAX_LEFT-1];
    logic [LW-1:0]  stk_vtx_reg [0:MAX_LEFT-1];
    logic [DW-1:0]  stk_pos_reg [0:MAX_LEFT-1];
    logic [LW-1:0]  lc_reg;
    logic [RW-1:0]  rc_reg;
    logic [VW-1:0]  v_reg;
    logic [TW-1:0]  head_reg;
    logic [TW-1:0]  tail_reg;
    logic [TW-1:0]  top_reg;
    logic [LW-1:0]  u_reg;
    logic [DW-1:0]  k_reg;
    logic [TW-1:0]  lay_u_reg;
    logic [1:0]     res_reg;
    logic           found_reg;
    logic [LW-1:0]  matched_reg;
    logic [EW-1:0]  e_reg;
    logic           result_valid_reg;
    bmm_pkg::result_t result_reg;

    logic           add_ok;
    logic [LW-1:0]  lv_idx;
    logic           deg_full;
    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [EDW-1:0] ram_wdata;
    logic [EDW-1:0] ram_rdata;
    logic [RW-1:0]  r_cur;
    logic           r_ok;
    logic [LW-1:0]  w_cur;
    logic [LW-1:0]  lc_eff;
    logic [RW-1:0]  rc_eff;
    logic [LW-1:0]  v_idx;
    logic [QW-1:0]  stk_top_idx;
    logic [QW-1:0]  stk_new_idx;
    logic           k_in_list;
    logic           emit_right;
    logic [LW-1:0]  emit_lid;
    logic [RW-1:0]  emit_rid;
    logic           emit_last;
    logic           emit_load;
    bmm_pkg::result_t emit_beat;

    assign item_stall   = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    always_comb
    begin
        add_ok = (item_data.left_vertex != 6'd0) && (int'(item_data.left_vertex) <= MAX_LEFT)
              && (item_data.right_vertex != 6'd0)
              && (int'(item_data.right_vertex) <= MAX_RIGHT);
        lv_idx   = add_ok ? LW'(item_data.left_vertex) : LW'(1);
        deg_full = (int'(degree_reg[lv_idx]) >= MAX_DEGREE);
        ram_we   = (state_reg == S_IDLE) && item_valid && (item_data.op == bmm_pkg::OP_ADD)
                && add_ok && !deg_full;
        ram_wdata = EDW'(int'(item_data.right_vertex) - 1);
        if (state_reg == S_IDLE)
        begin
            ram_addr = AW'((int'(lv_idx) - 1) * MAX_DEGREE + int'(degree_reg[lv_idx]));
        end
        else
        begin
            ram_addr = AW'((int'(u_reg) - 1) * MAX_DEGREE + int'(k_reg));
        end

        r_cur = RW'(int'(ram_rdata) + 1);
        r_ok  = (r_cur <= rc_reg);
        w_cur = right_partner_reg[r_cur];

        // counts of zero act as one, oversize counts clip to the maximum
        if (left_count_reg == 6'd0)
            lc_eff = LW'(1);
        else if (int'(left_count_reg) > MAX_LEFT)
            lc_eff = LW'(MAX_LEFT);
        else
            lc_eff = LW'(left_count_reg);
        if (right_count_reg == 6'd0)
            rc_eff = RW'(1);
        else if (int'(right_count_reg) > MAX_RIGHT)
            rc_eff = RW'(MAX_RIGHT);
        else
            rc_eff = RW'(right_count_reg);

        v_idx       = v_reg[LW-1:0];
        stk_top_idx = QW'(top_reg - 1'b1);
        stk_new_idx = QW'(top_reg);
        k_in_list   = (k_reg < degree_reg[u_reg]);

        emit_right = (e_reg > EW'(lc_reg));
        emit_lid   = LW'(e_reg);
        emit_rid   = RW'(e_reg - EW'(lc_reg));
        emit_last  = (e_reg == EW'(lc_reg) + EW'(rc_reg));
        emit_beat.side          = emit_right;
        emit_beat.vertex        = emit_right ? 6'(emit_rid) : 6'(emit_lid);
        emit_beat.partner       = emit_right ? 6'(right_partner_reg[emit_rid])
                                             : 6'(left_partner_reg[emit_lid]);
        emit_beat.in_cover      = emit_right ? reach_right_reg[emit_rid]
                                             : !reach_left_reg[emit_lid];
        emit_beat.match_size    = 6'(matched_reg);
        emit_beat.edge_overflow = overflow_reg;
        emit_beat.last          = emit_last;
        emit_load = (state_reg == S_EMIT) && (!result_valid_reg || !result_stall);
    end

    bmm_ram #(
        .WIDTH(EDW),
        .DEPTH(MAX_LEFT * MAX_DEGREE)
    ) u_edge_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            left_count_reg   <= bmm_pkg::COUNT_RESET;
            right_count_reg  <= bmm_pkg::COUNT_RESET;
            overflow_reg     <= 1'b0;
            lc_reg           <= '0;
            rc_reg           <= '0;
            v_reg            <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            top_reg          <= '0;
            u_reg            <= '0;
            k_reg            <= '0;
            lay_u_reg        <= '0;
            res_reg          <= RES_PEND;
            found_reg        <= 1'b0;
            matched_reg      <= '0;
            e_reg            <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            for (int i = 1; i <= MAX_LEFT; i++)
            begin
                degree_reg[i]       <= '0;
                left_partner_reg[i] <= '0;
                layer_reg[i]        <= '0;
                visited_reg[i]      <= 1'b0;
                reach_left_reg[i]   <= 1'b0;
            end
            for (int i = 0; i < MAX_LEFT; i++)
            begin
                queue_reg[i]   <= '0;
                stk_vtx_reg[i] <= '0;
                stk_pos_reg[i] <= '0;
            end
            for (int i = 1; i <= MAX_RIGHT; i++)
            begin
                right_partner_reg[i] <= '0;
                reach_right_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    bmm_pkg::CFG_LEFT_COUNT:  left_count_reg  <= cfg_data;
                    bmm_pkg::CFG_RIGHT_COUNT: right_count_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (emit_load)
            begin
                result_reg       <= emit_beat;
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        case (item_data.op)
                            bmm_pkg::OP_CLEAR:
                            begin
                                for (int i = 1; i <= MAX_LEFT; i++)
                                    degree_reg[i] <= '0;
                                overflow_reg <= 1'b0;
                            end
                            bmm_pkg::OP_ADD:
                            begin
                                if (add_ok)
                                begin
                                    if (deg_full)
                                        overflow_reg <= 1'b1;
                                    else
                                        degree_reg[lv_idx] <= degree_reg[lv_idx] + 1'b1;
                                end
                            end
                            bmm_pkg::OP_SOLVE:
                            begin
                                for (int i = 1; i <= MAX_LEFT; i++)
                                    left_partner_reg[i] <= '0;
                                for (int i = 1; i <= MAX_RIGHT; i++)
                                    right_partner_reg[i] <= '0;
                                lc_reg      <= lc_eff;
                                rc_reg      <= rc_eff;
                                matched_reg <= '0;
                                state_reg   <= S_BFS_INIT;
                            end
                            default: ;
                        endcase
                    end
                end

                S_BFS_INIT:
                begin
                    for (int i = 1; i <= MAX_LEFT; i++)
                        layer_reg[i] <= '0;
                    v_reg     <= VW'(1);
                    head_reg  <= '0;
                    tail_reg  <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_BFS_SEED;
                end

                S_BFS_SEED:
                begin
                    if (v_reg > VW'(lc_reg))
                    begin
                        state_reg <= S_BFS_POP;
                    end
                    else
                    begin
                        if (left_partner_reg[v_idx] == '0)
                        begin
                            layer_reg[v_idx]          <= TW'(1);
                            queue_reg[QW'(tail_reg)] <= v_idx;
                            tail_reg                  <= tail_reg + 1'b1;
                        end
                        v_reg <= v_reg + 1'b1;
                    end
                end

                S_BFS_POP:
                begin
                    if (head_reg < tail_reg)
                    begin
                        u_reg     <= queue_reg[QW'(head_reg)];
                        lay_u_reg <= layer_reg[queue_reg[QW'(head_reg)]];
                        k_reg     <= '0;
                        head_reg  <= head_reg + 1'b1;
                        state_reg <= S_BFS_REQ;
                    end
                    else if (found_reg)
                    begin
                        for (int i = 1; i <= MAX_LEFT; i++)
                            visited_reg[i] <= 1'b0;
                        v_reg     <= VW'(1);
                        state_reg <= S_AUG_SCAN;
                    end
                    else
                    begin
                        for (int i = 1; i <= MAX_LEFT; i++)
                            reach_left_reg[i] <= 1'b0;
                        for (int i = 1; i <= MAX_RIGHT; i++)
                            reach_right_reg[i] <= 1'b0;
                        v_reg     <= VW'(1);
                        top_reg   <= '0;
                        state_reg <= S_MARK_SCAN;
                    end
                end

                S_BFS_REQ:
                    state_reg <= k_in_list ? S_BFS_USE : S_BFS_POP;

                S_BFS_USE:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (r_ok)
                    begin
                        if (w_cur == '0)
                        begin
                            found_reg <= 1'b1;
                        end
                        else if (layer_reg[w_cur] == '0 && int'(tail_reg) <= MAX_LEFT)
                        begin
                            layer_reg[w_cur]          <= lay_u_reg + 1'b1;
                            queue_reg[QW'(tail_reg)] <= w_cur;
                            tail_reg                  <= tail_reg + 1'b1;
                        end
                    end
                    state_reg <= S_BFS_REQ;
                end

                S_AUG_SCAN:
                begin
                    if (v_reg > VW'(lc_reg))
                    begin
                        state_reg <= S_BFS_INIT;
                    end
                    else if (left_partner_reg[v_idx] == '0 && !visited_reg[v_idx])
                    begin
                        visited_reg[v_idx] <= 1'b1;
                        stk_vtx_reg[0]     <= v_idx;
                        stk_pos_reg[0]     <= '0;
                        top_reg            <= TW'(1);
                        res_reg            <= RES_PEND;
                        state_reg          <= S_DFS_TOP;
                    end
                    else
                    begin
                        v_reg <= v_reg + 1'b1;
                    end
                end

                S_DFS_TOP:
                begin
                    if (top_reg == '0)
                    begin
                        if (res_reg == RES_OK)
                            matched_reg <= matched_reg + 1'b1;
                        v_reg     <= v_reg + 1'b1;
                        state_reg <= S_AUG_SCAN;
                    end
                    else
                    begin
                        u_reg     <= stk_vtx_reg[stk_top_idx];
                        lay_u_reg <= layer_reg[stk_vtx_reg[stk_top_idx]];
                        if (res_reg == RES_OK)
                        begin
                            k_reg     <= stk_pos_reg[stk_top_idx];
                            state_reg <= S_DFS_CREQ;
                        end
                        else if (res_reg == RES_FAIL)
                        begin
                            // child failed: resume the parent past that edge
                            k_reg     <= stk_pos_reg[stk_top_idx] + 1'b1;
                            res_reg   <= RES_PEND;
                            state_reg <= S_DFS_REQ;
                        end
                        else
                        begin
                            k_reg     <= stk_pos_reg[stk_top_idx];
                            state_reg <= S_DFS_REQ;
                        end
                    end
                end

                S_DFS_CREQ:
                    state_reg <= S_DFS_COMMIT;

                S_DFS_COMMIT:
                begin
                    left_partner_reg[u_reg]  <= r_cur;
                    right_partner_reg[r_cur] <= u_reg;
                    top_reg                  <= top_reg - 1'b1;
                    state_reg                <= S_DFS_TOP;
                end

                S_DFS_REQ:
                begin
                    if (k_in_list)
                    begin
                        state_reg <= S_DFS_USE;
                    end
                    else
                    begin
                        res_reg   <= RES_FAIL;
                        top_reg   <= top_reg - 1'b1;
                        state_reg <= S_DFS_TOP;
                    end
                end

                S_DFS_USE:
                begin
                    if (!r_ok)
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_DFS_REQ;
                    end
                    else if (w_cur == '0)
                    begin
                        left_partner_reg[u_reg]  <= r_cur;
                        right_partner_reg[r_cur] <= u_reg;
                        res_reg                  <= RES_OK;
                        top_reg                  <= top_reg - 1'b1;
                        state_reg                <= S_DFS_TOP;
                    end
                    else if (!visited_reg[w_cur] && layer_reg[w_cur] == lay_u_reg + 1'b1
                             && int'(top_reg) <= MAX_LEFT)
                    begin
                        stk_pos_reg[stk_top_idx] <= k_reg;
                        visited_reg[w_cur]       <= 1'b1;
                        stk_vtx_reg[stk_new_idx] <= w_cur;
                        stk_pos_reg[stk_new_idx] <= '0;
                        top_reg                  <= top_reg + 1'b1;
                        state_reg                <= S_DFS_TOP;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_DFS_REQ;
                    end
                end

                S_MARK_SCAN:
                begin
                    if (v_reg > VW'(lc_reg))
                    begin
                        e_reg     <= EW'(1);
                        state_reg <= S_EMIT;
                    end
                    else if (left_partner_reg[v_idx] != '0 || reach_left_reg[v_idx])
                    begin
                        v_reg <= v_reg + 1'b1;
                    end
                    else
                    begin
                        reach_left_reg[v_idx] <= 1'b1;
                        stk_vtx_reg[0]        <= v_idx;
                        top_reg               <= TW'(1);
                        state_reg             <= S_MARK_POP;
                    end
                end

                S_MARK_POP:
                begin
                    if (top_reg == '0)
                    begin
                        state_reg <= S_MARK_SCAN;
                    end
                    else
                    begin
                        u_reg     <= stk_vtx_reg[stk_top_idx];
                        k_reg     <= '0;
                        top_reg   <= top_reg - 1'b1;
                        state_reg <= S_MARK_REQ;
                    end
                end

                S_MARK_REQ:
                    state_reg <= k_in_list ? S_MARK_USE : S_MARK_POP;

                S_MARK_USE:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (r_ok)
                    begin
                        reach_right_reg[r_cur] <= 1'b1;
                        if (w_cur != '0 && w_cur <= lc_reg && !reach_left_reg[w_cur]
                            && int'(top_reg) <= MAX_LEFT)
                        begin
                            reach_left_reg[w_cur]    <= 1'b1;
                            stk_vtx_reg[stk_new_idx] <= w_cur;
                            top_reg                  <= top_reg + 1'b1;
                        end
                    end
                    state_reg <= S_MARK_REQ;
                end

                S_EMIT:
                begin
                    if (emit_load)
                    begin
                        e_reg <= e_reg + 1'b1;
                        if (emit_last)
                            state_reg <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/bmm_checker.sv =====
// bmm_checker: port-level assertions for the bipartite matching block
// depends on bmm_pkg; bound to bipartite_max_matching_cover at the end of this file
module bmm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_stall,
    input logic             result_valid,
    input logic             result_stall,
    input bmm_pkg::result_t result_data
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("stalled result beat changed");

    // no new item while a solve still has beats to deliver
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.last |-> item_stall)
    else $error("item taken in the middle of a solve");

    // right-side beats never go back to the left side within a solve
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && result_data.side && !result_data.last
        |=> !result_valid || result_data.side)
    else $error("left beat after right beat");

    // a free left vertex is reached, so it is never in the cover
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.side && result_data.partner == 6'd0
        |-> !result_data.in_cover)
    else $error("free left vertex in cover");

endmodule

bind bipartite_max_matching_cover bmm_checker u_bmm_checker (.*);

// ===== tb/tb.sv =====
// tb: self-checking testbench of bipartite_max_matching_cover
// predicts every result beat with a matching and cover model in plain sv
// depends on bmm_pkg and the block's rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NL = 32;
    localparam int NR = 32;
    localparam int ND = 32;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEM_TARGET = 260;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    bmm_pkg::item_t   item_data;
    logic             result_valid;
    logic             result_stall;
    bmm_pkg::result_t result_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [5:0]       cfg_data;

    bipartite_max_matching_cover dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // matcher state
    int          adj [NL+1][ND];
    int          deg [NL+1];
    int          lmate [NL+1];
    int          rmate [NR+1];
    int          lay [NL+1];
    bit          seen [NL+1];
    bit          reach_l [NL+1];
    bit          reach_r [NR+1];
    bit          dropped;
    logic [5:0]  left_cnt;
    logic [5:0]  right_cnt;

    bmm_pkg::result_t pending_results[$];
    int          errors;
    int          n_items;
    int          cycles;
    bit          quiet_sink;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_count(logic [5:0] c, int maxv);
        if (c == 0)
            return 1;
        if (c > maxv)
            return maxv;
        return int'(c);
    endfunction

    function automatic bit layer_pass(int lc, int rc);
        bit found;
        int q [NL+1];
        int head, tail, u, r, w;
        found = 0;
        head = 0;
        tail = 0;
        for (int v = 0; v <= NL; v++)
            lay[v] = 0;
        for (int v = 1; v <= lc; v++)
        begin
            if (lmate[v] == 0)
            begin
                lay[v] = 1;
                q[tail++] = v;
            end
        end
        while (head < tail)
        begin
            u = q[head++];
            for (int k = 0; k < deg[u]; k++)
            begin
                r = adj[u][k];
                if (r > rc)
                    continue;
                w = rmate[r];
                if (w == 0)
                    found = 1;
                else if (lay[w] == 0 && tail <= NL)
                begin
                    lay[w] = lay[u] + 1;
                    q[tail++] = w;
                end
            end
        end
        return found;
    endfunction

    function automatic bit augment_from(int root, int rc);
        int sv [NL+1];
        int sp [NL+1];
        int top, res, u, k, r, w;
        bit pushed;
        top = 1;
        res = -1;
        seen[root] = 1;
        sv[0] = root;
        sp[0] = 0;
        while (top > 0)
        begin
            u = sv[top-1];
            k = sp[top-1];
            pushed = 0;
            if (res == 1)
            begin
                // unwind: flip the edge that led down
                r = adj[u][k];
                lmate[u] = r;
                rmate[r] = u;
                top--;
                continue;
            end
            if (res == 0)
            begin
                k++;
                res = -1;
            end
            while (k < deg[u])
            begin
                r = adj[u][k];
                if (r > rc)
                begin
                    k++;
                    continue;
                end
                w = rmate[r];
                if (w == 0)
                begin
                    lmate[u] = r;
                    rmate[r] = u;
                    res = 1;
                    break;
                end
                if (!seen[w] && lay[w] == lay[u] + 1 && top <= NL)
                begin
                    sp[top-1] = k;
                    seen[w] = 1;
                    sv[top] = w;
                    sp[top] = 0;
                    top++;
                    pushed = 1;
                    break;
                end
                k++;
            end
            if (res == 1)
            begin
                top--;
                continue;
            end
            if (pushed)
                continue;
            res = 0;
            top--;
        end
        return res == 1;
    endfunction

    function automatic void mark_alternating(int lc, int rc);
        int st [NL+1];
        int top, u, r, w;
        top = 0;
        for (int v = 0; v <= NL; v++)
            reach_l[v] = 0;
        for (int v = 0; v <= NR; v++)
            reach_r[v] = 0;
        for (int v = 1; v <= lc; v++)
        begin
            if (lmate[v] != 0 || reach_l[v])
                continue;
            reach_l[v] = 1;
            st[top++] = v;
            while (top > 0)
            begin
                u = st[--top];
                for (int k = 0; k < deg[u]; k++)
                begin
                    r = adj[u][k];
                    if (r > rc)
                        continue;
                    reach_r[r] = 1;
                    w = rmate[r];
                    if (w != 0 && w <= lc && !reach_l[w] && top <= NL)
                    begin
                        reach_l[w] = 1;
                        st[top++] = w;
                    end
                end
            end
        end
    endfunction

    function automatic void predict_matching(bmm_pkg::item_t it);
        int lc, rc, matched, id;
        bit rside;
        bmm_pkg::result_t res;
        case (it.op)
            bmm_pkg::OP_CLEAR:
            begin
                for (int v = 0; v <= NL; v++)
                    deg[v] = 0;
                dropped = 0;
            end
            bmm_pkg::OP_ADD:
            begin
                if (it.left_vertex == 0 || it.left_vertex > NL ||
                    it.right_vertex == 0 || it.right_vertex > NR)
                    return;
                if (deg[it.left_vertex] >= ND)
                    dropped = 1;
                else
                begin
                    adj[it.left_vertex][deg[it.left_vertex]] = int'(it.right_vertex);
                    deg[it.left_vertex]++;
                end
            end
            bmm_pkg::OP_SOLVE:
            begin
                lc = clamp_count(left_cnt, NL);
                rc = clamp_count(right_cnt, NR);
                matched = 0;
                for (int v = 0; v <= NL; v++)
                    lmate[v] = 0;
                for (int v = 0; v <= NR; v++)
                    rmate[v] = 0;
                while (layer_pass(lc, rc))
                begin
                    for (int v = 0; v <= NL; v++)
                        seen[v] = 0;
                    for (int v = 1; v <= lc; v++)
                        if (lmate[v] == 0 && !seen[v] && augment_from(v, rc))
                            matched++;
                end
                mark_alternating(lc, rc);
                for (int v = 1; v <= lc + rc; v++)
                begin
                    rside = v > lc;
                    id = rside ? v - lc : v;
                    res.side = rside;
                    res.vertex = 6'(id);
                    res.partner = 6'(rside ? rmate[id] : lmate[id]);
                    res.in_cover = rside ? reach_r[id] : !reach_l[id];
                    res.match_size = 6'(matched);
                    res.edge_overflow = dropped;
                    res.last = (v == lc + rc);
                    pending_results = {pending_results, res};
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch in %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // result side: check each accepted beat
    always @(posedge clk)
    begin
        bmm_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report("unexpected beat vertex", int'(result_data.vertex), 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_data.side !== want.side)
                    report("side", int'(result_data.side), int'(want.side));
                if (result_data.vertex !== want.vertex)
                    report("vertex", int'(result_data.vertex), int'(want.vertex));
                if (result_data.partner !== want.partner)
                    report("partner", int'(result_data.partner), int'(want.partner));
                if (result_data.in_cover !== want.in_cover)
                    report("in_cover", int'(result_data.in_cover), int'(want.in_cover));
                if (result_data.match_size !== want.match_size)
                    report("match_size", int'(result_data.match_size),
                           int'(want.match_size));
                if (result_data.edge_overflow !== want.edge_overflow)
                    report("edge_overflow", int'(result_data.edge_overflow),
                           int'(want.edge_overflow));
                if (result_data.last !== want.last)
                    report("last", int'(result_data.last), int'(want.last));
            end
        end
    end

    // sink back-pressure with quiet stretches
    initial
    begin
        int hold, r;
        hold = 0;
        quiet_sink = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 299) == 0)
                quiet_sink = ~quiet_sink;
            if (hold > 0)
            begin
                hold--;
                result_stall <= 1'b1;
            end
            else if (!quiet_sink && $urandom_range(0, 3) == 0)
            begin
                r = $urandom_range(0, 99);
                hold = (r < 85) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_item(bmm_pkg::item_t it);
        int r, gap;
        r = $urandom_range(0, 99);
        gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item_data <= it;
        do
            @(posedge clk);
        while (item_stall);
        predict_matching(it);
        n_items++;
        @(negedge clk);
    endtask

    task automatic send_op(logic [1:0] op, logic [5:0] lv, logic [5:0] rv);
        bmm_pkg::item_t it;
        it.op = op;
        it.left_vertex = lv;
        it.right_vertex = rv;
        send_item(it);
    endtask

    task automatic drain;
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_count(logic [1:0] idx, logic [5:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == bmm_pkg::CFG_LEFT_COUNT)
            left_cnt = val;
        else
            right_cnt = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one random graph: optional clear, edges with occasional nop or out-of-range adds, solve
    task automatic random_graph(int n_edges, int span_l, int span_r);
        if ($urandom_range(0, 3) != 0)
            send_op(bmm_pkg::OP_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        for (int i = 0; i < n_edges; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_op($urandom_range(0, 9) < 5 ? bmm_pkg::OP_NOP : bmm_pkg::OP_ADD,
                        6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            else
                send_op(bmm_pkg::OP_ADD, 6'($urandom_range(1, span_l)),
                        6'($urandom_range(1, span_r)));
        end
        send_op(bmm_pkg::OP_SOLVE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    endtask

    task automatic test_directed;
        send_op(bmm_pkg::OP_SOLVE, 6'd0, 6'd0);
        send_op(bmm_pkg::OP_ADD, 6'd1, 6'd1);
        send_op(bmm_pkg::OP_ADD, 6'd1, 6'd32);
        send_op(bmm_pkg::OP_ADD, 6'd32, 6'd1);
        send_op(bmm_pkg::OP_ADD, 6'd2, 6'd1);
        send_op(bmm_pkg::OP_ADD, 6'd0, 6'd5);
        send_op(bmm_pkg::OP_ADD, 6'd5, 6'd0);
        send_op(bmm_pkg::OP_ADD, 6'd33, 6'd3);
        send_op(bmm_pkg::OP_ADD, 6'd3, 6'd63);
        send_op(bmm_pkg::OP_NOP, 6'd63, 6'd63);
        send_op(bmm_pkg::OP_SOLVE, 6'd63, 6'd63);
        send_op(bmm_pkg::OP_CLEAR, 6'd0, 6'd0);
        send_op(bmm_pkg::OP_SOLVE, 6'd0, 6'd0);
    endtask

    task automatic test_overflow;
        send_op(bmm_pkg::OP_CLEAR, 6'd0, 6'd0);
        for (int i = 0; i < ND + 1; i++)
            send_op(bmm_pkg::OP_ADD, 6'd32, 6'($urandom_range(1, NR)));
        send_op(bmm_pkg::OP_ADD, 6'd31, 6'd7);
        send_op(bmm_pkg::OP_SOLVE, 6'd0, 6'd0);
        send_op(bmm_pkg::OP_CLEAR, 6'd0, 6'd0);
        send_op(bmm_pkg::OP_SOLVE, 6'd0, 6'd0);
    endtask

    task automatic test_counts;
        logic [5:0] vals [6] = '{6'd0, 6'd1, 6'd63, 6'd5, 6'd33, 6'd32};
        for (int i = 0; i < 6; i++)
        begin
            write_count(bmm_pkg::CFG_LEFT_COUNT, vals[i]);
            write_count(bmm_pkg::CFG_RIGHT_COUNT, vals[5 - i]);
            random_graph($urandom_range(4, 16), 12, 12);
        end
        write_count(bmm_pkg::CFG_LEFT_COUNT, 6'd32);
        write_count(bmm_pkg::CFG_RIGHT_COUNT, 6'd32);
    endtask

    task automatic test_random;
        int span;
        while (n_items < ITEM_TARGET)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                write_count(bmm_pkg::CFG_LEFT_COUNT, 6'($urandom_range(0, 63)));
                write_count(bmm_pkg::CFG_RIGHT_COUNT, 6'($urandom_range(0, 63)));
            end
            span = $urandom_range(0, 3) == 0 ? 32 : $urandom_range(2, 8);
            random_graph($urandom_range(0, 24), span, $urandom_range(2, 32));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item_data = '0;
        cfg_valid = 1'b0;
        cfg_index = bmm_pkg::CFG_LEFT_COUNT;
        cfg_data = '0;
        errors = 0;
        n_items = 0;
        cycles = 0;
        dropped = 0;
        left_cnt = bmm_pkg::COUNT_RESET;
        right_cnt = bmm_pkg::COUNT_RESET;
        for (int v = 0; v <= NL; v++)
            deg[v] = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_overflow();
        test_counts();
        test_random();
        drain();
        repeat (50) @(negedge clk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
